### rtl/core/neighbor_outline_recolor_assert.svh
// assertion macros shared by the recolor block
`ifndef NEIGHBOR_OUTLINE_RECOLOR_ASSERT_SVH
`define NEIGHBOR_OUTLINE_RECOLOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define NOR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define NOR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/nor_pkg.sv
`default_nettype none
package nor_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int WID_W   = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);
	localparam int DIM_W   = 11;
	localparam int RGB_W   = 24;
	localparam int ALPHA_W = 8;
	localparam int COORD_W = 10;
	localparam int PIX_W   = ALPHA_W + RGB_W;
	// line word: above-match flag on top of alpha and rgb
	localparam int LINE_W  = PIX_W + 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [ALPHA_W-1:0] FULL_ALPHA = 8'd255;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OUTLINE     = 3'd0,
		REG_TARGET      = 3'd1,
		REG_REPLACEMENT = 3'd2,
		REG_WIDTH       = 3'd3,
		REG_HEIGHT      = 3'd4
	} cfg_reg_e;

	typedef struct packed {
		logic [RGB_W-1:0]   pixel_color;
		logic [ALPHA_W-1:0] pixel_alpha;
		logic               flush;
	} pix_item_t;

	typedef struct packed {
		logic [RGB_W-1:0]   out_color;
		logic [ALPHA_W-1:0] out_alpha;
		logic [COORD_W-1:0] out_x;
		logic [COORD_W-1:0] out_y;
		logic               recolored;
		logic               last_of_frame;
	} res_item_t;

	typedef struct packed {
		logic [RGB_W-1:0] outline;
		logic [RGB_W-1:0] target;
		logic [RGB_W-1:0] replacement;
	} colors_t;

	// raster position of the item at the input, with its edge flags
	typedef struct packed {
		logic [COL_W-1:0] x;
		logic [COL_W-1:0] nx;
		logic [ROW_W-1:0] r;
		logic             pad;
		logic             right_ok;
		logic             last_col;
	} pos_t;

	typedef struct packed {
		pos_t             pos;
		logic [PIX_W-1:0] pixel;
	} stage_t;

endpackage
`default_nettype wire

### rtl/core/nor_line_ram.sv
`default_nettype none
module nor_line_ram #(
	parameter int DEPTH = 1024,
	parameter int DATA_W = 33,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr0,
	input  wire logic [ADDR_W-1:0] raddr1,
	output logic      [DATA_W-1:0] rdata0,
	output logic      [DATA_W-1:0] rdata1
);

	logic [DATA_W-1:0] mem [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule
`default_nettype wire

### rtl/core/nor_raster_ctr.sv
`default_nettype none
module nor_raster_ctr import nor_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [DIM_W-1:0] width,
	input  wire logic [DIM_W-1:0] height,
	input  wire logic             accept,
	input  wire logic             ignore,
	output pos_t                  pos
);

	localparam int CW1 = COL_W + 1;
	localparam int RW1 = ROW_W + 1;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [WID_W-1:0] w;
	logic [ROW_W-1:0] h;
	logic             wrap;
	logic [RW1-1:0]   r_tmp;
	logic [RW1-1:0]   r_inc;
	logic [CW1-1:0]   x_inc;
	logic [COL_W-1:0] col_d;
	logic [ROW_W-1:0] row_d;

	function automatic logic [WID_W-1:0] eff_width(input logic [DIM_W-1:0] v);
		logic [WID_W-1:0] e;
		if (v == '0) begin
			e = WID_W'(1);
		end else if (v > MAX_WIDTH) begin
			e = WID_W'(MAX_WIDTH);
		end else begin
			e = WID_W'(v);
		end
		return e;
	endfunction

	function automatic logic [ROW_W-1:0] eff_height(input logic [DIM_W-1:0] v);
		logic [ROW_W-1:0] e;
		if (v == '0) begin
			e = ROW_W'(1);
		end else if (v > MAX_HEIGHT) begin
			e = ROW_W'(MAX_HEIGHT);
		end else begin
			e = ROW_W'(v);
		end
		return e;
	endfunction

	always_comb begin
		w = eff_width(width);
		h = eff_height(height);
		// counters left past new bounds wrap first
		wrap = col_q >= w;
		r_tmp = RW1'(row_q) + RW1'(wrap);
		pos.x = wrap ? '0 : col_q;
		pos.r = (r_tmp > h) ? '0 : r_tmp[ROW_W-1:0];
		x_inc = CW1'(pos.x) + CW1'(1);
		pos.nx = x_inc[COL_W-1:0];
		pos.right_ok = x_inc < w;
		pos.last_col = x_inc == w;
		pos.pad = pos.r >= h;
		r_inc = RW1'(pos.r) + RW1'(1);
		if (ignore) begin
			col_d = pos.x;
			row_d = pos.r;
		end else if (!pos.right_ok) begin
			col_d = '0;
			row_d = (r_inc > h) ? '0 : r_inc[ROW_W-1:0];
		end else begin
			col_d = pos.nx;
			row_d = pos.r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

endmodule
`default_nettype wire

### rtl/core/nor_decide.sv
`default_nettype none
module nor_decide import nor_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  colors_t                colors,
	input  stage_t                 item,
	input  wire logic [LINE_W-1:0] prev,
	input  wire logic [LINE_W-1:0] nb,
	input  wire logic              adv,
	input  wire logic              res_stall,
	output logic                   has_res,
	output logic      [LINE_W-1:0] wdata,
	output logic                   res_valid,
	output res_item_t              res
);

	logic [RGB_W-1:0] prev_rgb;
	logic             prev_outline;
	logic             up;
	logic             left;
	logic             right;
	logic             down;
	logic             hit;
	logic             left_match_q;
	logic             res_valid_q;
	res_item_t        res_d;
	res_item_t        res_q;

	always_comb begin
		prev_rgb = prev[RGB_W-1:0];
		has_res = item.pos.r != '0;
		prev_outline = prev_rgb == colors.outline;
		up = (item.pos.r >= ROW_W'(2)) && prev[PIX_W];
		left = (item.pos.x != '0) && left_match_q;
		right = item.pos.right_ok && (nb[RGB_W-1:0] == colors.outline);
		down = !item.pos.pad && (item.pixel[RGB_W-1:0] == colors.outline);
		hit = (prev_rgb == colors.target) && (up || left || right || down);

		res_d.out_color = hit ? colors.replacement : prev_rgb;
		res_d.out_alpha = hit ? FULL_ALPHA : prev[PIX_W-1:RGB_W];
		res_d.out_x = COORD_W'(item.pos.x);
		res_d.out_y = COORD_W'(item.pos.r - ROW_W'(1));
		res_d.recolored = hit;
		res_d.last_of_frame = item.pos.pad && item.pos.last_col;

		// padding keeps the stored pixel, row 0 keeps the stored flag
		wdata[PIX_W] = has_res ? prev_outline : prev[PIX_W];
		wdata[PIX_W-1:0] = item.pos.pad ? prev[PIX_W-1:0] : item.pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_match_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv && has_res) begin
				left_match_q <= prev_outline;
			end
			if (adv && has_res) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_res) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule
`default_nettype wire

### rtl/core/neighbor_outline_recolor.sv
`default_nettype none
// four-neighbor outline recolor on a raster pixel stream. pixels come in
// on the pix channel in raster order, one item per clock when nothing
// stalls; a pixel whose rgb equals target_color leaves as replacement_color
// with alpha 255 if a neighbor above, below, left or right of it (inside
// the image) has the outline color, else it leaves unchanged. a pixel is
// decided when the pixel below it arrives, so results lag one row: send
// one padding row (image_width items, flush set or not) after each frame,
// and its last result carries last_of_frame. flush items inside the frame
// rows are taken and dropped. row 0 items give no result. the prior row
// lives in one line ram (one write, two reads per clock: the pixel above
// and the one above-right), so the sustained rate is one item per clock
// while the output does not stall, and each result is registered. there is
// no clearing pass after reset. write the registers only while idle.
`include "neighbor_outline_recolor_assert.svh"
module neighbor_outline_recolor import nor_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration write port
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	// pixel items in
	input  wire logic                  pix_valid,
	output logic                       pix_stall,
	input  pix_item_t                  pix,
	// decided pixels out
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output res_item_t                  res
);

	// configuration registers
	colors_t          colors_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	// input side
	pos_t             pos;
	logic             accept;
	logic             ignore;
	logic             enter;

	// decide stage
	logic             valid_s1;
	stage_t           item_s1;
	logic             fwd0_s1;
	logic             fwd1_s1;
	logic [LINE_W-1:0] fwd_data_s1;
	logic             s1_adv;
	logic             s1_has_res;

	// line ram
	logic [LINE_W-1:0] rdata0;
	logic [LINE_W-1:0] rdata1;
	logic [LINE_W-1:0] prev;
	logic [LINE_W-1:0] nb;
	logic [LINE_W-1:0] wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colors_q <= '0;
			width_q <= DIM_W'(640);
			height_q <= DIM_W'(480);
		end else if (cfg_we) begin
			case (cfg_reg_e'(cfg_index))
				REG_OUTLINE:     colors_q.outline <= cfg_wdata[RGB_W-1:0];
				REG_TARGET:      colors_q.target <= cfg_wdata[RGB_W-1:0];
				REG_REPLACEMENT: colors_q.replacement <= cfg_wdata[RGB_W-1:0];
				REG_WIDTH:       width_q <= cfg_wdata[DIM_W-1:0];
				REG_HEIGHT:      height_q <= cfg_wdata[DIM_W-1:0];
				default: begin
					// unused indexes are dropped
				end
			endcase
		end
	end

	nor_raster_ctr u_ctr (
		.clk    (clk),
		.arst_n (arst_n),
		.width  (width_q),
		.height (height_q),
		.accept (accept),
		.ignore (ignore),
		.pos    (pos)
	);

	// decide stage moves on unless its result would overrun a stalled output
	assign s1_adv = valid_s1 && (!s1_has_res || !res_valid || !res_stall);
	assign pix_stall = valid_s1 && !s1_adv;
	assign accept = pix_valid && !pix_stall;
	// a flush item inside the frame rows is consumed and dropped
	assign ignore = pix.flush && !pos.pad;
	assign enter = accept && !ignore;

	nor_line_ram #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (LINE_W)
	) u_line (
		.clk    (clk),
		.we     (s1_adv),
		.waddr  (item_s1.pos.x),
		.wdata  (wdata),
		.re     (enter),
		.raddr0 (pos.x),
		.raddr1 (pos.nx),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (enter) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// a write landing on the edge of the read is missed by the ram,
	// so the written word is kept and steered in next cycle
	always_ff @(posedge clk) begin
		if (enter) begin
			item_s1.pos <= pos;
			item_s1.pixel <= {pix.pixel_alpha, pix.pixel_color};
			fwd0_s1 <= s1_adv && (item_s1.pos.x == pos.x);
			fwd1_s1 <= s1_adv && (item_s1.pos.x == pos.nx);
			fwd_data_s1 <= wdata;
		end
	end

	assign prev = fwd0_s1 ? fwd_data_s1 : rdata0;
	assign nb = fwd1_s1 ? fwd_data_s1 : rdata1;

	nor_decide u_decide (
		.clk       (clk),
		.arst_n    (arst_n),
		.colors    (colors_q),
		.item      (item_s1),
		.prev      (prev),
		.nb        (nb),
		.adv       (s1_adv),
		.res_stall (res_stall),
		.has_res   (s1_has_res),
		.wdata     (wdata),
		.res_valid (res_valid),
		.res       (res)
	);

	// a decided pixel with a result always reaches the output register
	`NOR_ASSERT_NXT(a_res_loaded, s1_adv && s1_has_res, res_valid, "result not loaded")
	// input backpressure only comes from a full, stalled output
	`NOR_ASSERT_IMP(a_stall_cause, pix_stall, valid_s1 && res_valid && res_stall, "bad stall")
	// recolored pixels carry the replacement color at full alpha
	`NOR_ASSERT_IMP(a_recolor_val, res_valid && res.recolored, res.out_alpha == FULL_ALPHA && res.out_color == colors_q.replacement, "bad recolor")

endmodule
`default_nettype wire

### tb/sv/recolor_checker.sv
`timescale 1ns / 1ps
module recolor_checker import nor_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  pix_valid,
	input  logic                  pix_stall,
	input  pix_item_t             pix,
	input  logic                  res_valid,
	input  logic                  res_stall,
	input  res_item_t             res,
	output int unsigned           outstanding,
	output int unsigned           mismatches
);

	localparam int unsigned RESET_WIDTH  = 640;
	localparam int unsigned RESET_HEIGHT = 480;
	localparam int unsigned PRINT_CAP    = 100;

	// register copies
	logic [RGB_W-1:0] outline_c;
	logic [RGB_W-1:0] target_c;
	logic [RGB_W-1:0] fill_c;
	logic [DIM_W-1:0] width_c;
	logic [DIM_W-1:0] height_c;

	// prior row and raster position
	logic [PIX_W-1:0] line_px [MAX_WIDTH];
	bit               above_hit [MAX_WIDTH];
	bit               left_hit;
	int unsigned      col;
	int unsigned      row;

	res_item_t due_q [$];
	res_item_t made;
	res_item_t want;

	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v,
			input int unsigned ceiling);
		if (v == 0) return 1;
		if (v > ceiling) return ceiling;
		return v;
	endfunction

	// one pixel in; returns 1 when it decides the pixel above it
	function automatic bit advance_raster(input pix_item_t it, output res_item_t r);
		int unsigned      w;
		int unsigned      h;
		int unsigned      x;
		int unsigned      y;
		logic [PIX_W-1:0] above;
		bit               pad;
		bit               up;
		bit               left;
		bit               right;
		bit               down;
		bit               hit;
		w = clamp_dim(width_c, MAX_WIDTH);
		h = clamp_dim(height_c, MAX_HEIGHT);
		r = '0;
		// counters left past new bounds by a register write
		if (col >= w) begin
			col = 0;
			row++;
		end
		if (row > h) row = 0;
		x = col;
		y = row;
		pad = (y >= h);
		// flush inside the frame rows is dropped without a trace
		if (it.flush && !pad) return 1'b0;
		if (y > 0) begin
			above = line_px[x];
			up    = (y >= 2) && above_hit[x];
			left  = (x > 0) && left_hit;
			right = (x + 1 < w) && (line_px[x + 1][RGB_W-1:0] == outline_c);
			down  = !pad && (it.pixel_color == outline_c);
			hit   = (above[RGB_W-1:0] == target_c) && (up || left || right || down);
			r.out_color     = hit ? fill_c : above[RGB_W-1:0];
			r.out_alpha     = hit ? FULL_ALPHA : above[PIX_W-1:RGB_W];
			r.out_x         = x[COORD_W-1:0];
			r.out_y         = COORD_W'(y - 1);
			r.recolored     = hit;
			r.last_of_frame = pad && (x == w - 1);
			above_hit[x] = (above[RGB_W-1:0] == outline_c);
			left_hit     = above_hit[x];
		end
		if (!pad) line_px[x] = {it.pixel_alpha, it.pixel_color};
		col = x + 1;
		if (col >= w) begin
			col = 0;
			row = y + 1;
			if (row > h) row = 0;
		end
		return y > 0;
	endfunction

	task automatic flag(input string msg);
		if (mismatches < PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string field, input logic [31:0] got,
			input logic [31:0] ideal);
		if (got !== ideal)
			flag($sformatf("pixel (%0d,%0d) %s: got %0h, wanted %0h",
				want.out_x, want.out_y, field, got, ideal));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outline_c = '0;
			target_c  = '0;
			fill_c    = '0;
			width_c   = DIM_W'(RESET_WIDTH);
			height_c  = DIM_W'(RESET_HEIGHT);
			left_hit  = 1'b0;
			col       = 0;
			row       = 0;
			due_q.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (due_q.size() == 0) begin
					flag($sformatf("pixel (%0d,%0d) came out with nothing pending",
						res.out_x, res.out_y));
				end else begin
					want = due_q.pop_front();
					check_field("out_color", res.out_color, want.out_color);
					check_field("out_alpha", res.out_alpha, want.out_alpha);
					check_field("out_x", res.out_x, want.out_x);
					check_field("out_y", res.out_y, want.out_y);
					check_field("recolored", res.recolored, want.recolored);
					check_field("last_of_frame", res.last_of_frame, want.last_of_frame);
				end
			end
			if (cfg_we) begin
				case (cfg_reg_e'(cfg_index))
					REG_OUTLINE:     outline_c = cfg_wdata[RGB_W-1:0];
					REG_TARGET:      target_c  = cfg_wdata[RGB_W-1:0];
					REG_REPLACEMENT: fill_c    = cfg_wdata[RGB_W-1:0];
					REG_WIDTH:       width_c   = cfg_wdata[DIM_W-1:0];
					REG_HEIGHT:      height_c  = cfg_wdata[DIM_W-1:0];
					default: ;
				endcase
			end
			if (pix_valid && !pix_stall) begin
				if (advance_raster(pix, made)) due_q.push_back(made);
			end
			outstanding <= due_q.size();
		end
	end

endmodule

### tb/sv/tb_neighbor_outline_recolor.sv
`timescale 1ns / 1ps
module tb_neighbor_outline_recolor;
	import nor_pkg::*;

	// cycles to wait after the last pending pixel has come out
	localparam int unsigned DRAIN        = 16;
	// non-flush items to push in the random part
	localparam int unsigned RANDOM_ITEMS = 60;
	// percent of cycles that either side sits idle
	localparam int unsigned IDLE_PCT     = 30;
	localparam int unsigned ALL_ITEMS    = 32'hFFFF_FFFF;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  pix_valid;
	logic                  pix_stall;
	pix_item_t             pix;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	res_item_t             res;

	int unsigned outstanding;
	int unsigned mismatches;

	// register values as last written, stimulus sizes frames from these
	logic [CFG_DATA_W-1:0] reg_val [REG_OUTLINE:REG_HEIGHT];
	// no idling on either side while set
	bit                    steady;
	// percent chance of a stray flush item ahead of each frame pixel
	int unsigned           flush_pct;

	neighbor_outline_recolor i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	recolor_checker i_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.pix         (pix),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver backpressure, random except in the steady stretch
	always @(posedge clk) begin
		res_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
	end

	// hard stop well past the slowest legal run
	initial begin
		#4_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic int unsigned span(input logic [CFG_DATA_W-1:0] v);
		if (v[DIM_W-1:0] == 0) return 1;
		if (v[DIM_W-1:0] > MAX_WIDTH) return MAX_WIDTH;
		return v[DIM_W-1:0];
	endfunction

	function automatic pix_item_t pixel_item(input logic [RGB_W-1:0] c,
			input logic [ALPHA_W-1:0] a, input logic f);
		pixel_item.pixel_color = c;
		pixel_item.pixel_alpha = a;
		pixel_item.flush       = f;
	endfunction

	// bias toward the configured colors so neighbors actually match
	function automatic logic [RGB_W-1:0] pick_color();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 35) return reg_val[REG_TARGET][RGB_W-1:0];
		if (roll < 60) return reg_val[REG_OUTLINE][RGB_W-1:0];
		if (roll < 65) return reg_val[REG_REPLACEMENT][RGB_W-1:0];
		return $urandom();
	endfunction

	// one item on the pix channel, held until taken
	task automatic push_pixel(input pix_item_t it);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= it;
		do begin
			@(posedge clk);
		end while (pix_stall);
	endtask

	// drop valid and let every pending pixel come out before touching registers
	task automatic settle();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// write the selected registers from reg_val, one per clock
	task automatic write_regs(input bit [REG_HEIGHT:REG_OUTLINE] sel);
		for (int i = REG_OUTLINE; i <= REG_HEIGHT; i++) begin
			if (sel[i]) begin
				cfg_we    <= 1'b1;
				cfg_index <= cfg_reg_e'(i);
				cfg_wdata <= reg_val[i];
				@(posedge clk);
			end
		end
		cfg_we <= 1'b0;
	endtask

	// frame rows then the padding row, stopping early after cut items;
	// stray flushes inside the rows do not count
	task automatic send_frame(input int unsigned cut, output int unsigned done_items);
		int unsigned w;
		int unsigned body;
		int unsigned total;
		w     = span(reg_val[REG_WIDTH]);
		body  = w * span(reg_val[REG_HEIGHT]);
		total = body + w;
		done_items = 0;
		while (done_items < total && done_items < cut) begin
			if (done_items < body && $urandom_range(0, 99) < flush_pct)
				push_pixel(pixel_item($urandom(), $urandom(), 1'b1));
			// padding row mostly flagged, but the flag is not what makes it padding
			push_pixel(pixel_item(pick_color(), $urandom(),
				(done_items >= body) ? ($urandom_range(0, 3) != 0) : 1'b0));
			done_items++;
		end
	endtask

	initial begin
		int unsigned sent;
		int unsigned n;
		int unsigned w;
		int unsigned total;
		int unsigned cut;
		int unsigned rr;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_OUTLINE;
		cfg_wdata <= '0;
		pix_valid <= 1'b0;
		pix       <= '0;
		steady    = 1'b0;
		flush_pct = 0;
		sent      = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hand-built 3x3 frame, white outline around black targets
		reg_val[REG_OUTLINE]     = 24'hFF_FFFF;
		reg_val[REG_TARGET]      = 24'h00_0000;
		reg_val[REG_REPLACEMENT] = 24'h5A_A55A;
		reg_val[REG_WIDTH]       = 3;
		reg_val[REG_HEIGHT]      = 3;
		write_regs('1);
		// row 0: target with outline to its right, outline, target with outline left
		push_pixel(pixel_item(24'h00_0000, 8'h00, 1'b0));
		push_pixel(pixel_item(24'hFF_FFFF, 8'h7F, 1'b0));
		push_pixel(pixel_item(24'h00_0000, 8'hFF, 1'b0));
		// row 1: target with outline below, stray flush, target under outline, other
		push_pixel(pixel_item(24'h00_0000, 8'h01, 1'b0));
		push_pixel(pixel_item(24'h80_8080, 8'h00, 1'b1));
		push_pixel(pixel_item(24'h00_0000, 8'h80, 1'b0));
		push_pixel(pixel_item(24'h80_8080, 8'h10, 1'b0));
		// row 2: outline, target with outline left, target with no outline near
		push_pixel(pixel_item(24'hFF_FFFF, 8'h00, 1'b0));
		push_pixel(pixel_item(24'h00_0000, 8'hFE, 1'b0));
		push_pixel(pixel_item(24'h00_0000, 8'h33, 1'b0));
		// padding: an unflagged outline-colored item must not act as a lower neighbor
		push_pixel(pixel_item(24'h80_8080, 8'h00, 1'b1));
		push_pixel(pixel_item(24'hFF_FFFF, 8'hFF, 1'b0));
		push_pixel(pixel_item(24'hFF_FFFF, 8'h00, 1'b1));
		settle();

		// zero dimensions act as a 1x1 image
		reg_val[REG_OUTLINE]     = 24'h00_0000;
		reg_val[REG_TARGET]      = 24'hFF_FFFF;
		reg_val[REG_REPLACEMENT] = 24'hFF_FFFF;
		reg_val[REG_WIDTH]       = 0;
		reg_val[REG_HEIGHT]      = 0;
		write_regs('1);
		send_frame(ALL_ITEMS, n);
		settle();

		// width shrunk mid-row: column past the new width wraps to the next row
		reg_val[REG_OUTLINE]     = 24'h00_FF00;
		reg_val[REG_TARGET]      = 24'h00_00FF;
		reg_val[REG_REPLACEMENT] = 24'hFF_0000;
		reg_val[REG_WIDTH]       = 4;
		reg_val[REG_HEIGHT]      = 3;
		write_regs('1);
		send_frame(7, n);
		settle();
		reg_val[REG_WIDTH] = 2;
		write_regs(1 << REG_WIDTH);
		// rest of row 2 and the padding row at the new width
		repeat (4) push_pixel(pixel_item(pick_color(), $urandom(), 1'b0));
		settle();

		// height shrunk below the current row: row count wraps to a new frame
		reg_val[REG_HEIGHT] = 3;
		write_regs(1 << REG_HEIGHT);
		send_frame(4, n);
		settle();
		reg_val[REG_HEIGHT] = 1;
		write_regs(1 << REG_HEIGHT);
		send_frame(ALL_ITEMS, n);
		settle();

		// widest row, clamped from an oversized value; stop a few items into
		// the padding row, then close it through a 1x1 frame
		reg_val[REG_OUTLINE]     = $urandom();
		reg_val[REG_TARGET]      = $urandom();
		reg_val[REG_REPLACEMENT] = $urandom();
		reg_val[REG_WIDTH]       = 2047;
		reg_val[REG_HEIGHT]      = 1;
		write_regs('1);
		send_frame(MAX_WIDTH + 4, n);
		settle();
		reg_val[REG_WIDTH]  = 1;
		reg_val[REG_HEIGHT] = 1;
		write_regs((1 << REG_WIDTH) | (1 << REG_HEIGHT));
		push_pixel(pixel_item(pick_color(), $urandom(), 1'b0));
		push_pixel(pixel_item(pick_color(), $urandom(), 1'b1));
		settle();

		// tall column, one pixel per row, with no idling anywhere
		reg_val[REG_HEIGHT] = 60;
		write_regs(1 << REG_HEIGHT);
		steady = 1'b1;
		send_frame(ALL_ITEMS, n);
		settle();
		steady = 1'b0;

		// random frames: mostly small, sometimes back to back, some cut short
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 70) begin
				settle();
				reg_val[REG_OUTLINE] = $urandom();
				// target equal to outline, replacement equal to outline now and then
				reg_val[REG_TARGET] = ($urandom_range(0, 9) == 0) ?
					reg_val[REG_OUTLINE] : $urandom();
				reg_val[REG_REPLACEMENT] = ($urandom_range(0, 9) == 0) ?
					reg_val[REG_OUTLINE] : $urandom();
				w = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) :
					$urandom_range(9, 40);
				reg_val[REG_WIDTH]  = w;
				reg_val[REG_HEIGHT] = (w > 8) ? $urandom_range(1, 2) : $urandom_range(1, 7);
				write_regs('1);
			end
			flush_pct = ($urandom_range(0, 1) == 0) ? 0 : 6;
			w     = span(reg_val[REG_WIDTH]);
			total = w * (span(reg_val[REG_HEIGHT]) + 1);
			cut   = (total > 1 && $urandom_range(0, 99) < 12) ?
				$urandom_range(1, total - 1) : total;
			send_frame(cut, n);
			sent += n;
			if (n < total) begin
				// broken frame: shrink to 1x1 so the counters wrap, then run a
				// 1x1 frame to its end so the next frame starts at row 0
				rr = (n % w != 0) ? n / w + 1 : n / w;
				settle();
				reg_val[REG_WIDTH]  = $urandom_range(0, 1);
				reg_val[REG_HEIGHT] = $urandom_range(0, 1);
				write_regs((1 << REG_WIDTH) | (1 << REG_HEIGHT));
				if (rr > 1) push_pixel(pixel_item(pick_color(), $urandom(), 1'b0));
				push_pixel(pixel_item(pick_color(), $urandom(),
					$urandom_range(0, 1)));
			end
		end
		flush_pct = 0;
		settle();

		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
